@@ src/ising_metropolis_spin_update_top_macros.svh @@
// assertion macros for the ising spin update checker
`ifndef ISING_METROPOLIS_SPIN_UPDATE_TOP_MACROS_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ISU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ISU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/isu_pkg.sv @@
// shared types, constants and helpers of the ising spin update block
package isu_pkg;

	// lattice geometry, side must be a power of two
	localparam int SIDE    = 64;
	localparam int COL_W   = $clog2(SIDE);
	localparam int CELLS   = SIDE * SIDE;
	localparam int SITE_W  = 12;
	localparam int NTHRESH = 5;
	localparam int THR_W   = 17;
	localparam int IDX_W   = $clog2(NTHRESH);
	localparam int RND_W   = 16;
	localparam int ENER_W  = 17;
	localparam int DE_W    = 4;
	localparam int UP_W    = 13;
	localparam int CFG_IDX_W = 3;

	localparam logic [THR_W-1:0] THR_RESET = 17'd65536;

	typedef enum logic [1:0] {
		ACT_LOAD       = 2'd0,
		ACT_FLIP       = 2'd1,
		ACT_SET_ENERGY = 2'd2,
		ACT_NONE       = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		RD_ABOVE = 2'd0,
		RD_BELOW = 2'd1,
		RD_ROW   = 2'd2
	} rd_sel_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_ABOVE,
		ST_RD_BELOW,
		ST_RD_ROW,
		ST_GET_ROW,
		ST_COMMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load_item;
		logic    clear_wr;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_above;
		logic    cap_below;
		logic    cap_row;
		logic    commit;
	} isu_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic out_free;
	} isu_status_t;

	// clamp an 18-bit signed energy into -32768..32768
	function automatic logic signed [ENER_W-1:0] clamp_energy(input logic signed [ENER_W:0] v);
		logic signed [ENER_W-1:0] r;
		r = v[ENER_W-1:0];
		if (v > 18'sd32768) begin
			r = 17'sd32768;
		end else if (v < -18'sd32768) begin
			r = -17'sd32768;
		end
		return r;
	endfunction

endpackage

@@ src/ising_metropolis_spin_update_top.sv @@
// top level of the 2d ising metropolis single spin flip unit
// Keeps a 64 by 64 lattice of one-bit spins with periodic wraparound in a row-wide
// memory (64 rows of 64 bits) and runs one item at a time. A Metropolis attempt reads
// the row above, the row below and the site's own row through the memory's single read
// port, counts the up neighbours, picks one of five acceptance thresholds and writes
// the row back on a flip. An accepted item passes the states RD_ABOVE, RD_BELOW, RD_ROW,
// GET_ROW and COMMIT before it reaches the result register, and no new item is taken
// before that; COMMIT waits while an earlier result still waits on m_tready. Spin loads and
// energy loads run the same sequence. After reset a clearing pass zeroes the lattice one
// row per cycle, all 64 rows, during which s_tready stays low; threshold writes on the
// cfg channel are taken in every cycle and should only be made while the unit is idle.
module ising_metropolis_spin_update_top (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // site[11:0], spin_value[12], random_u[28:13],
	                               // energy_value[45:29], zero fill
	input  logic [1:0]  s_tuser,   // action: load spin, metropolis attempt, set energy
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // accepted[0], delta_energy[4:1], spin_after[5],
	                               // up_total[18:6], energy_total[35:19], zero fill
	// threshold register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [isu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [isu_pkg::THR_W-1:0]     cfg_data
);

	isu_pkg::isu_cmd_t    cmd;
	isu_pkg::isu_status_t status;

	logic                                 accepted, spin_after;
	logic signed [isu_pkg::DE_W-1:0]      delta_energy;
	logic [isu_pkg::UP_W-1:0]             up_total;
	logic signed [isu_pkg::ENER_W-1:0]    energy_total;

	// thresholds are plain registers, always writable
	assign cfg_ready = 1'b1;

	// sequencer
	isu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// lattice, arithmetic and result register
	isu_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.action       (s_tuser),
		.site         (s_tdata[11:0]),
		.spin_value   (s_tdata[12]),
		.random_u     (s_tdata[28:13]),
		.energy_value (s_tdata[45:29]),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.accepted     (accepted),
		.delta_energy (delta_energy),
		.spin_after   (spin_after),
		.up_total     (up_total),
		.energy_total (energy_total)
	);

	// result packing, first field in the low bits
	assign m_tdata = {4'b0000, energy_total, up_total, spin_after, delta_energy, accepted};

endmodule

@@ src/isu_ctrl.sv @@
// sequencer: clearing pass, three row reads, commit
module isu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  isu_pkg::isu_status_t status,
	output isu_pkg::isu_cmd_t   cmd
);

	isu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isu_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.rd_sel = isu_pkg::RD_ROW;
		in_ready = 1'b0;
		unique case (state_q)
			isu_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last) begin
					state_d = isu_pkg::ST_IDLE;
				end
			end
			isu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = isu_pkg::ST_RD_ABOVE;
				end
			end
			isu_pkg::ST_RD_ABOVE: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = isu_pkg::RD_ABOVE;
				state_d = isu_pkg::ST_RD_BELOW;
			end
			isu_pkg::ST_RD_BELOW: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = isu_pkg::RD_BELOW;
				cmd.cap_above = 1'b1;
				state_d = isu_pkg::ST_RD_ROW;
			end
			isu_pkg::ST_RD_ROW: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = isu_pkg::RD_ROW;
				cmd.cap_below = 1'b1;
				state_d = isu_pkg::ST_GET_ROW;
			end
			isu_pkg::ST_GET_ROW: begin
				cmd.cap_row = 1'b1;
				state_d = isu_pkg::ST_COMMIT;
			end
			isu_pkg::ST_COMMIT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d = isu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = isu_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/isu_datapath.sv @@
// lattice row memory, neighbour count, acceptance test, counters and result register
module isu_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  isu_pkg::isu_cmd_t                    cmd,
	output isu_pkg::isu_status_t                 status,
	input  logic [1:0]                           action,
	input  logic [isu_pkg::SITE_W-1:0]           site,
	input  logic                                 spin_value,
	input  logic [isu_pkg::RND_W-1:0]            random_u,
	input  logic signed [isu_pkg::ENER_W-1:0]    energy_value,
	input  logic                                 cfg_wr,
	input  logic [isu_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [isu_pkg::THR_W-1:0]            cfg_data,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic                                 accepted,
	output logic signed [isu_pkg::DE_W-1:0]      delta_energy,
	output logic                                 spin_after,
	output logic [isu_pkg::UP_W-1:0]             up_total,
	output logic signed [isu_pkg::ENER_W-1:0]    energy_total
);

	localparam int SIDE  = isu_pkg::SIDE;
	localparam int COL_W = isu_pkg::COL_W;

	// thresholds
	logic [isu_pkg::THR_W-1:0] thr_q [isu_pkg::NTHRESH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < isu_pkg::NTHRESH; k++) begin
				thr_q[k] <= isu_pkg::THR_RESET;
			end
		end else if (cfg_wr && ({1'b0, cfg_index} < (isu_pkg::CFG_IDX_W+1)'(isu_pkg::NTHRESH))) begin
			thr_q[cfg_index[isu_pkg::IDX_W-1:0]] <= cfg_data;
		end
	end

	// item registers
	isu_pkg::action_t                      action_q;
	logic [isu_pkg::SITE_W-1:0]            site_q;
	logic                                  spin_q;
	logic [isu_pkg::RND_W-1:0]             rnd_q;
	logic signed [isu_pkg::ENER_W-1:0]     ev_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= isu_pkg::action_t'(action);
			site_q   <= site;
			spin_q   <= spin_value;
			rnd_q    <= random_u;
			ev_q     <= energy_value;
		end
	end

	logic [COL_W-1:0] col, col_r, col_l, row, row_up, row_dn;
	assign col    = site_q[COL_W-1:0];
	assign row    = site_q[COL_W +: COL_W];
	assign col_r  = col + 1'b1;
	assign col_l  = col - 1'b1;
	assign row_up = row + 1'b1;
	assign row_dn = row - 1'b1;

	// row-wide lattice memory, one read and one write port
	logic [SIDE-1:0] lat_mem_q [SIDE];
	logic [SIDE-1:0] rd_data_q;
	logic [COL_W-1:0] rd_addr, wr_addr;
	logic [SIDE-1:0] wr_data;
	logic            wr_en;

	always_comb begin
		unique case (cmd.rd_sel)
			isu_pkg::RD_ABOVE: rd_addr = row_up;
			isu_pkg::RD_BELOW: rd_addr = row_dn;
			isu_pkg::RD_ROW:   rd_addr = row;
			default:           rd_addr = row;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lat_mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= lat_mem_q[rd_addr];
		end
	end

	// clearing pass counter
	logic [COL_W-1:0] clr_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_row_q <= clr_row_q + 1'b1;
		end
	end

	assign status.clear_last = (clr_row_q == COL_W'(SIDE - 1));

	// neighbour rows
	logic [SIDE-1:0] above_q, below_q, row_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_above) above_q <= rd_data_q;
		if (cmd.cap_below) below_q <= rd_data_q;
		if (cmd.cap_row)   row_q   <= rd_data_q;
	end

	// evaluation
	logic                               self_spin, in_range, flip_ok, new_self, item_we;
	logic [2:0]                         n_up, thr_idx;
	logic [3:0]                         n2;
	logic signed [isu_pkg::DE_W-1:0]    de_calc, de_out;
	logic                               acc;
	logic [isu_pkg::THR_W-1:0]          thr;
	logic [isu_pkg::UP_W-1:0]           up_q, up_next;
	logic signed [isu_pkg::ENER_W-1:0]  energy_q, energy_next;
	logic signed [isu_pkg::ENER_W:0]    e_sum;
	logic [SIDE-1:0]                    new_row;

	assign self_spin = row_q[col];
	assign n_up = 3'(above_q[col]) + 3'(below_q[col]) + 3'(row_q[col_r]) + 3'(row_q[col_l]);
	assign n2 = {n_up, 1'b0};
	assign de_calc = self_spin ? $signed(4'(n2 - 4'd4)) : $signed(4'(4'd4 - n2));
	assign thr_idx = self_spin ? n_up : 3'(3'd4 - n_up);
	assign thr = thr_q[thr_idx];
	assign flip_ok = ({1'b0, rnd_q} < thr);
	assign in_range = ({1'b0, site_q} < (isu_pkg::SITE_W+1)'(isu_pkg::CELLS));
	assign e_sum = {energy_q[isu_pkg::ENER_W-1], energy_q}
		+ {{(isu_pkg::ENER_W - isu_pkg::DE_W){de_calc[isu_pkg::DE_W-1]}}, de_calc, 1'b0};

	always_comb begin
		new_self    = self_spin;
		item_we     = 1'b0;
		acc         = 1'b0;
		de_out      = '0;
		up_next     = up_q;
		energy_next = energy_q;
		if (in_range) begin
			unique case (action_q)
				isu_pkg::ACT_LOAD: begin
					new_self = spin_q;
					item_we  = 1'b1;
					if (self_spin != spin_q) begin
						up_next = spin_q ? up_q + 1'b1 : up_q - 1'b1;
					end
				end
				isu_pkg::ACT_FLIP: begin
					de_out = de_calc;
					if (flip_ok) begin
						acc      = 1'b1;
						new_self = !self_spin;
						item_we  = 1'b1;
						up_next  = self_spin ? up_q - 1'b1 : up_q + 1'b1;
						energy_next = isu_pkg::clamp_energy(e_sum);
					end
				end
				isu_pkg::ACT_SET_ENERGY: begin
					energy_next = isu_pkg::clamp_energy({ev_q[isu_pkg::ENER_W-1], ev_q});
				end
				isu_pkg::ACT_NONE: begin
				end
				default: begin
				end
			endcase
		end
		new_row = row_q;
		new_row[col] = new_self;
	end

	assign wr_en   = cmd.clear_wr || (cmd.commit && item_we);
	assign wr_addr = cmd.clear_wr ? clr_row_q : row;
	assign wr_data = cmd.clear_wr ? '0 : new_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q     <= '0;
			energy_q <= '0;
		end else if (cmd.commit) begin
			up_q     <= up_next;
			energy_q <= energy_next;
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			accepted     <= acc;
			delta_energy <= de_out;
			spin_after   <= in_range ? new_self : 1'b0;
			up_total     <= up_next;
			energy_total <= energy_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

@@ src/isu_checker.sv @@
// port-level checker for the ising spin update top, bound to the top level
`include "ising_metropolis_spin_update_top_macros.svh"

module isu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// a stalled result holds
	`ISU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// delta energy is always even
	`ISU_ASSERT_NOW(a_de_even, m_tvalid, !m_tdata[1], "odd delta energy")

	// up count never exceeds the lattice size
	`ISU_ASSERT_NOW(a_up_range, m_tvalid, m_tdata[18:6] <= 13'd4096, "up count out of range")

	// energy stays within -32768..32768
	`ISU_ASSERT_NOW(a_energy_range, m_tvalid, m_tdata[35] ? m_tdata[34] : (!m_tdata[34] || (m_tdata[33:19] == 15'd0)), "energy out of range")

endmodule

bind ising_metropolis_spin_update_top isu_checker u_isu_checker (.*);
